// ===== sv/sparse_sigmoid_net_eval_defines.svh =====
// Assertion macros for the sparse sigmoid network evaluator.
// Used by the port checker; expects clk and rst in scope.
`ifndef SPARSE_SIGMOID_NET_EVAL_DEFINES_SVH
`define SPARSE_SIGMOID_NET_EVAL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssn check failed");

// Next-cycle implication, disabled during reset.
`define SSN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssn check failed");

// Next-cycle implication that also holds across reset.
`define SSN_ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ssn check failed");

`endif

// ===== sv/ssn_pkg.sv =====
// Shared types, codes and the sigmoid table for the sparse sigmoid evaluator.
// No dependencies.
package ssn_pkg;

  localparam int DEF_MAX_NODES       = 64;
  localparam int DEF_MAX_CONNECTIONS = 256;
  localparam int DEF_VALUE_BITS      = 16;

  // Item function codes
  localparam logic [1:0] FN_CONN  = 2'd0;
  localparam logic [1:0] FN_INPUT = 2'd1;
  localparam logic [1:0] FN_EVAL  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_INPUTS  = 2'd0;
  localparam logic [1:0] REG_OUTPUTS = 2'd1;
  localparam logic [1:0] REG_CONNS   = 2'd2;
  localparam logic [1:0] REG_SLOPE   = 2'd3;

  localparam logic [5:0]  RST_INPUTS  = 6'd2;
  localparam logic [5:0]  RST_OUTPUTS = 6'd1;
  localparam logic [8:0]  RST_CONNS   = 9'd0;
  localparam logic [15:0] RST_SLOPE   = 16'd20070;

  typedef struct packed {
    logic               on;
    logic [5:0]         src;
    logic [5:0]         dst;
    logic signed [15:0] w;
  } conn_entry_t;

  // sigma(k/2) * 4096, rounded, k = 0..16
  function automatic logic [11:0] sig_tab(input logic [4:0] idx);
    logic [11:0] v;
    unique case (idx)
      5'd0:  v = 12'd2048;
      5'd1:  v = 12'd2550;
      5'd2:  v = 12'd2994;
      5'd3:  v = 12'd3349;
      5'd4:  v = 12'd3608;
      5'd5:  v = 12'd3785;
      5'd6:  v = 12'd3902;
      5'd7:  v = 12'd3976;
      5'd8:  v = 12'd4022;
      5'd9:  v = 12'd4051;
      5'd10: v = 12'd4069;
      5'd11: v = 12'd4079;
      5'd12: v = 12'd4086;
      5'd13: v = 12'd4090;
      5'd14: v = 12'd4092;
      5'd15: v = 12'd4094;
      default: v = 12'd4095;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/ssn_if.sv =====
// Handshake channels of the sparse sigmoid evaluator: request, result, config.
// No dependencies.
interface ssn_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [7:0]         conn_slot;
  logic [5:0]         src_node;
  logic [5:0]         dst_node;
  logic signed [15:0] weight;
  logic               conn_on;
  logic [5:0]         input_slot;
  logic signed [15:0] input_value;

  modport source (output valid, func, conn_slot, src_node, dst_node, weight, conn_on,
                  input_slot, input_value, input ready);
  modport sink (input valid, func, conn_slot, src_node, dst_node, weight, conn_on,
                input_slot, input_value, output ready);
endinterface

interface ssn_rsp_if;
  logic        valid;
  logic        ready;
  logic [5:0]  out_index;
  logic [12:0] out_value;
  logic        last;

  modport source (output valid, out_index, out_value, last, input ready);
  modport sink (input valid, out_index, out_value, last, output ready);
endinterface

interface ssn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/sparse_sigmoid_net_eval.sv =====
// Sparse sigmoid network evaluator: connection table, node and field memories.
// Depends on ssn_pkg and the channel interfaces in ssn_if.sv.
// Write items (connection, input) are accepted only while idle. An evaluate item
// runs the connection walk, then the sigmoid sweep over all MAX_NODES nodes, then
// returns each output result in turn; each memory has a single read port.
// Synchronous reset clears the valid bits so nodes, fields and inputs read as zero.
module sparse_sigmoid_net_eval import ssn_pkg::*; #(
  parameter int MAX_NODES       = DEF_MAX_NODES,
  parameter int MAX_CONNECTIONS = DEF_MAX_CONNECTIONS,
  parameter int VALUE_BITS      = DEF_VALUE_BITS
) (
  input logic        clk,
  input logic        rst,
  ssn_req_if.sink    req,
  ssn_rsp_if.source  rsp,
  ssn_cfg_if.sink    cfg
);

  localparam int NB      = $clog2(MAX_NODES);
  localparam int IO_MAX  = MAX_NODES - 2;
  localparam int IB      = $clog2(IO_MAX);
  localparam int CB      = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
  localparam int KB      = $clog2(MAX_CONNECTIONS + 1);
  localparam int SRC_W   = (VALUE_BITS > 14) ? VALUE_BITS : 14;
  localparam int PROD_W  = 16 + SRC_W;
  localparam int SUM_W   = (PROD_W > 32) ? PROD_W + 1 : 33;
  localparam longint VMAX = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;

  localparam logic [1:0] SRC_INPUT = 2'd0;
  localparam logic [1:0] SRC_BIAS  = 2'd1;
  localparam logic [1:0] SRC_NODE  = 2'd2;

  typedef enum logic [2:0] {ST_IDLE, ST_WALK, ST_SIG, ST_OREAD, ST_OWAIT, ST_OHOLD} state_t;

  state_t state;

  // configuration registers
  logic [5:0]  input_count, output_count;
  logic [8:0]  connection_count;
  logic [15:0] sigmoid_slope;

  // counts latched at the start of an evaluation
  logic [NB-1:0] ni, no;
  logic [KB-1:0] nc;

  // memories
  conn_entry_t                  conn_mem  [MAX_CONNECTIONS];
  logic signed [VALUE_BITS-1:0] in_mem    [IO_MAX];
  logic signed [VALUE_BITS-1:0] node_mem  [MAX_NODES];
  logic signed [31:0]           field_mem [MAX_NODES];

  conn_entry_t                  tab_rd;
  logic signed [VALUE_BITS-1:0] in_rd, node_rd;
  logic signed [31:0]           field_rd;

  logic [MAX_NODES-1:0] ivalid, nvalid, fvalid;

  // walk pipeline
  logic [KB-1:0]       k;
  logic                s1v, s2v, s3v, wbv;
  logic [NB-1:0]       s2_dst, s3_dst, wb_dst;
  logic signed [15:0]  s2_w;
  logic [1:0]          s2_sel;
  logic                s2_ok;
  logic signed [PROD_W-1:0] s3_prod;
  logic signed [31:0]  s3_field, wb_val;

  // sigmoid pipeline
  logic [NB:0]         si;
  logic                p1v, p2v, p3v;
  logic [NB-1:0]       p1a, p2a, p3a;
  logic                p2neg, p3neg;
  logic [31:0]         p2mag;
  logic [47:0]         p3t;

  // output sequencing
  logic [NB-1:0]       oi;

  // combinational
  logic                req_fire, conn_we, in_we, walk_issue, sig_issue;
  logic                s1_ok;
  logic [NB-1:0]       s1_src, s1_dst, node_ra, field_ra, out_addr;
  logic [1:0]          s1_sel;
  logic signed [SRC_W-1:0]  s2_val;
  logic signed [PROD_W-1:0] s2_prod;
  logic signed [31:0]  s2_field, acc_sat, p1_field;
  logic signed [SUM_W-1:0]  s3_sum;
  logic [11:0]         tab_lo, tab_hi, tab_d;
  logic [24:0]         interp;
  logic [12:0]         pos, sig_res;
  logic signed [VALUE_BITS-1:0] node_wd;
  logic [NB-1:0]       ni_c, no_c;
  logic [KB-1:0]       nc_c;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign conn_we   = req_fire && (req.func == FN_CONN) && (32'(req.conn_slot) < MAX_CONNECTIONS);
  assign in_we     = req_fire && (req.func == FN_INPUT) && (32'(req.input_slot) < IO_MAX);

  // clamp the counts to the node and table sizes
  always_comb begin
    int a, b, c;
    a = int'(input_count);
    if (a > IO_MAX) a = IO_MAX;
    b = int'(output_count);
    if (b > MAX_NODES - a - 1) b = MAX_NODES - a - 1;
    if (b > IO_MAX) b = IO_MAX;
    c = int'(connection_count);
    if (c > MAX_CONNECTIONS) c = MAX_CONNECTIONS;
    ni_c = NB'(a);
    no_c = NB'(b);
    nc_c = KB'(c);
  end

  // stage 1: decode the table entry, pick where the source value comes from
  assign s1_ok  = s1v && tab_rd.on && (32'(tab_rd.src) < MAX_NODES)
                  && (32'(tab_rd.dst) < MAX_NODES);
  assign s1_src = NB'(tab_rd.src);
  assign s1_dst = NB'(tab_rd.dst);
  always_comb begin
    if (s1_src < ni)       s1_sel = SRC_INPUT;
    else if (s1_src == ni) s1_sel = SRC_BIAS;
    else                   s1_sel = SRC_NODE;
  end

  assign walk_issue = (state == ST_WALK) && (k < nc);
  assign sig_issue  = (state == ST_SIG) && (si < (NB+1)'(MAX_NODES));
  assign out_addr   = ni + NB'(1) + oi;
  assign node_ra    = (state == ST_OREAD) ? out_addr : s1_src;
  assign field_ra   = (state == ST_SIG) ? si[NB-1:0] : s1_dst;

  // stage 2: source value and field operand, forwarded from the two writes
  // that the memory read cannot yet see
  always_comb begin
    unique case (s2_sel)
      SRC_INPUT: s2_val = s2_ok ? SRC_W'(in_rd) : '0;
      SRC_BIAS:  s2_val = SRC_W'(4096);
      default:   s2_val = s2_ok ? SRC_W'(node_rd) : '0;
    endcase
  end
  assign s2_prod = s2_w * s2_val;

  always_comb begin
    priority if (s3v && (s3_dst == s2_dst)) s2_field = acc_sat;
    else if (wbv && (wb_dst == s2_dst))     s2_field = wb_val;
    else if (fvalid[s2_dst])                s2_field = field_rd;
    else                                    s2_field = '0;
  end

  // stage 3: accumulate and saturate to 32 bits
  assign s3_sum = s3_field + s3_prod;
  always_comb begin
    if (s3_sum[SUM_W-1:31] == '0 || s3_sum[SUM_W-1:31] == '1) acc_sat = 32'(s3_sum);
    else if (s3_sum[SUM_W-1])                                  acc_sat = 32'sh8000_0000;
    else                                                       acc_sat = 32'sh7fff_ffff;
  end

  // sigmoid: table lookup and linear interpolation on |slope * field|
  assign p1_field = fvalid[p1a] ? field_rd : '0;
  assign tab_lo   = sig_tab({1'b0, p3t[38:35]});
  assign tab_hi   = sig_tab(5'({1'b0, p3t[38:35]}) + 5'd1);
  assign tab_d    = tab_hi - tab_lo;
  assign interp   = 25'(tab_d) * 25'(p3t[34:23]) + 25'd2048;
  assign pos      = (|p3t[47:39]) ? 13'd4095 : 13'(tab_lo) + 13'(interp[23:12]);
  assign sig_res  = p3neg ? 13'd4096 - pos : pos;
  assign node_wd  = (longint'(sig_res) > VMAX) ? VALUE_BITS'(VMAX) : VALUE_BITS'(sig_res);

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (conn_we) begin
      conn_mem[CB'(req.conn_slot)] <= '{on: req.conn_on, src: req.src_node,
                                        dst: req.dst_node, w: req.weight};
    end
    tab_rd <= conn_mem[k[CB-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_we) in_mem[IB'(req.input_slot)] <= VALUE_BITS'(req.input_value);
    in_rd <= in_mem[IB'(s1_src)];
  end

  always_ff @(posedge clk) begin
    if (p3v) node_mem[p3a] <= node_wd;
    node_rd <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (s3v) field_mem[s3_dst] <= acc_sat;
    field_rd <= field_mem[field_ra];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_count      <= RST_INPUTS;
      output_count     <= RST_OUTPUTS;
      connection_count <= RST_CONNS;
      sigmoid_slope    <= RST_SLOPE;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_INPUTS:  input_count      <= cfg.data[5:0];
        REG_OUTPUTS: output_count     <= cfg.data[5:0];
        REG_CONNS:   connection_count <= cfg.data[8:0];
        REG_SLOPE:   sigmoid_slope    <= cfg.data;
      endcase
    end
  end

  // payload stages: no reset needed
  always_ff @(posedge clk) begin
    s2_dst   <= s1_dst;
    s2_w     <= tab_rd.w;
    s2_sel   <= s1_sel;
    s2_ok    <= (s1_sel == SRC_INPUT) ? ivalid[s1_src] : nvalid[s1_src];
    s3_dst   <= s2_dst;
    s3_prod  <= s2_prod;
    s3_field <= s2_field;
    wb_dst   <= s3_dst;
    wb_val   <= acc_sat;
    p2a      <= p1a;
    p2neg    <= p1_field[31];
    p2mag    <= p1_field[31] ? 32'(-p1_field) : 32'(p1_field);
    p3a      <= p2a;
    p3neg    <= p2neg;
    p3t      <= 48'(p2mag) * 48'(sigmoid_slope);
  end

  // control: sequencer, valid bits and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ivalid    <= '0;
      nvalid    <= '0;
      fvalid    <= '0;
      s1v       <= 1'b0;
      s2v       <= 1'b0;
      s3v       <= 1'b0;
      wbv       <= 1'b0;
      p1v       <= 1'b0;
      p2v       <= 1'b0;
      p3v       <= 1'b0;
      k         <= '0;
      si        <= '0;
      oi        <= '0;
      ni        <= '0;
      no        <= '0;
      nc        <= '0;
      p1a       <= '0;
      rsp.valid <= 1'b0;
      rsp.out_index <= '0;
      rsp.out_value <= '0;
      rsp.last  <= 1'b0;
    end else begin
      s1v <= walk_issue;
      s2v <= s1_ok;
      s3v <= s2v;
      wbv <= s3v;
      p1v <= sig_issue;
      p2v <= p1v;
      p3v <= p2v;
      if (walk_issue) k <= k + KB'(1);
      if (sig_issue) begin
        si  <= si + (NB+1)'(1);
        p1a <= si[NB-1:0];
      end
      if (in_we) ivalid[IB'(req.input_slot)] <= 1'b1;
      if (s3v) fvalid[s3_dst] <= 1'b1;
      if (p3v) nvalid[p3a] <= 1'b1;

      unique case (state)
        ST_IDLE: begin
          if (req_fire && (req.func == FN_EVAL)) begin
            // clear every field, latch the counts
            fvalid <= '0;
            k      <= '0;
            ni     <= ni_c;
            no     <= no_c;
            nc     <= nc_c;
            state  <= ST_WALK;
          end
        end
        ST_WALK: begin
          if ((k == nc) && !s1v && !s2v && !s3v) begin
            si    <= '0;
            state <= ST_SIG;
          end
        end
        ST_SIG: begin
          if (!sig_issue && !p1v && !p2v && !p3v) begin
            oi    <= '0;
            state <= (no == '0) ? ST_IDLE : ST_OREAD;
          end
        end
        ST_OREAD: state <= ST_OWAIT;
        ST_OWAIT: begin
          rsp.valid     <= 1'b1;
          rsp.out_index <= 6'(oi);
          rsp.out_value <= nvalid[out_addr] ? 13'(node_rd) : '0;
          rsp.last      <= (oi == no - NB'(1));
          state         <= ST_OHOLD;
        end
        ST_OHOLD: begin
          if (rsp.ready) begin
            rsp.valid <= 1'b0;
            if (rsp.last) begin
              state <= ST_IDLE;
            end else begin
              oi    <= oi + NB'(1);
              state <= ST_OREAD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/ssn_checker.sv =====
// Port-level checks for the sparse sigmoid evaluator, bound to the top level.
// Depends on ssn_pkg and sparse_sigmoid_net_eval_defines.svh.
`include "sparse_sigmoid_net_eval_defines.svh"

module ssn_checker import ssn_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_func,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [12:0] rsp_out_value,
  input logic        rsp_last
);

  `SSN_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_value) && $stable(rsp_last))
  `SSN_ASSERT_IMP(a_busy_while_result, rsp_valid, !req_ready)
  `SSN_ASSERT_NXT(a_eval_goes_busy, req_valid && req_ready && (req_func == FN_EVAL), !req_ready && !rsp_valid)
  `SSN_ASSERT_NXT_RST(a_reset_quiet, rst, !rsp_valid && req_ready)

endmodule

bind sparse_sigmoid_net_eval ssn_checker u_ssn_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_func      (req.func),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_out_value (rsp.out_value),
  .rsp_last      (rsp.last)
);
